// ===== hdl/spe_pkg.sv =====
`default_nettype none

package spe_pkg;

    // Datapath widths.
    localparam int PHASE_W       = 48;
    localparam int CXY_W         = 34;
    localparam int CZ_W          = 33;
    localparam int TERM_W        = 14;
    localparam int CORDIC_STEPS  = 18;
    localparam int STAGE_STEPS   = 3;
    localparam int CORDIC_STAGES = CORDIC_STEPS / STAGE_STEPS;
    localparam int PAIRS         = 128;

    typedef logic signed [CXY_W-1:0] t_cxy;
    typedef logic signed [CZ_W-1:0]  t_cz;

    // Fixed-point constants of the encoding.
    localparam logic [63:0] LOG2_1E4_Q32 = 64'd57070290109;
    localparam logic [63:0] INV_2PI_Q32  = 64'd683565276;
    // Two pi in nanoradians is 2^32 plus this remainder.
    localparam logic [63:0] TWO_PI_LO    = 64'd1988218011;
    localparam logic [63:0] ROUND_Q32    = 64'd2147483648;
    localparam t_cxy CORDIC_GAIN_Q30     = 34'sd652032874;
    localparam t_cxy Q12_ROUND           = 34'sd131072;
    localparam t_cxy TERM_HI             = 34'sd4096;
    localparam t_cxy TERM_LO             = -34'sd4096;

    // Arctangent of 2^-i in nanoradians.
    localparam t_cz ATAN_NRAD [CORDIC_STEPS] = '{
        33'sd785398163, 33'sd463647609, 33'sd244978663, 33'sd124354995,
        33'sd62418810,  33'sd31239833,  33'sd15623729,  33'sd7812341,
        33'sd3906230,   33'sd1953123,   33'sd976562,    33'sd488281,
        33'sd244141,    33'sd122070,    33'sd61035,     33'sd30518,
        33'sd15259,     33'sd7629
    };

    typedef enum logic [1:0] {
        QUAD_I,
        QUAD_II,
        QUAD_III,
        QUAD_IV
    } t_quad;

    // Sideband that travels with each item down the pipeline.
    typedef struct packed {
        logic               valid;
        logic               use_cos;
        logic               in_range;
        t_quad              quad;
        logic signed [15:0] embed;
    } t_spe_ctrl;

    typedef struct packed {
        logic signed [15:0] embed_value;
        logic [8:0]         position;
        logic [7:0]         hidden_index;
    } t_spe_in;

    typedef struct packed {
        logic signed [15:0] sum_value;
        logic               saturated;
    } t_spe_out;

    // Integer square root, used only while the frequency table is built.
    function automatic logic [63:0] sqrt_floor(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] bitv;
        v    = v_in;
        r    = '0;
        bitv = 64'd1 << 62;
        for (int k = 0; k < 32; k++) begin
            if (v >= r + bitv) begin
                v = v - (r + bitv);
                r = (r >> 1) + bitv;
            end else begin
                r = r >> 1;
            end
            bitv = bitv >> 2;
        end
        return r;
    endfunction

    // Frequency in Q48 turns per position from the Q32 exponent y = log2 of the divisor.
    function automatic logic [PHASE_W-1:0] freq_from_y(input logic [63:0] y);
        logic [63:0] c;
        logic [63:0] m;
        logic [31:0] n;
        logic [31:0] f;
        logic [63:0] p;
        n = y[63:32];
        f = y[31:0];
        c = 64'd1 << 31;
        m = 64'd1 << 32;
        for (int b = 31; b >= 0; b--) begin
            c = sqrt_floor(c << 32);
            if (f[b]) begin
                m = (m * c + ROUND_Q32) >> 32;
            end
        end
        p = (m * INV_2PI_Q32) >> (16 + n);
        if (n > 32'd40) begin
            p = '0;
        end
        return p[PHASE_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== hdl/sinusoidal_position_encoding_add.sv =====
// A result strobes o_done when the item of its start transfer reaches the result register of the last stage.
// Throughput: one item per cycle; busy is always low and the pipeline never stalls.
// The pace is set by the 11-stage pipeline: table read, phase multiply, radian scaling,
// six CORDIC stages of three micro-rotations each, output mapping and the saturating add.
// Reset is synchronous and active low; it clears the valid bits of every stage.
`default_nettype none

module sinusoidal_position_encoding_add
    import spe_pkg::*;
#(
    parameter int HIDDEN = 256
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    start,
    output logic         busy,
    input  wire t_spe_in i_in,
    output logic         o_done,
    output t_spe_out     o_result
);

    // Frequency of one sine/cosine pair, computed at elaboration.
    function automatic logic [PHASE_W-1:0] f_freq(input int g);
        logic [63:0] e;
        logic [63:0] y;
        e = 64'(2 * g);
        y = (e * LOG2_1E4_Q32) / 64'(HIDDEN);
        return freq_from_y(y);
    endfunction

    logic [PHASE_W-1:0] w_freq_rom [PAIRS];

    for (genvar g = 0; g < PAIRS; g++) begin : g_rom
        localparam logic [PHASE_W-1:0] FREQ_G = (2 * g < HIDDEN) ? f_freq(g) : '0;
        assign w_freq_rom[g] = FREQ_G;
    end

    // Stage 1: table lookup and index range check.
    t_spe_ctrl          r_s1_ctrl, n_s1_ctrl;
    logic [PHASE_W-1:0] r_s1_freq;
    logic [8:0]         r_s1_pos;

    always_comb begin
        n_s1_ctrl.valid    = start;
        n_s1_ctrl.use_cos  = i_in.hidden_index[0];
        n_s1_ctrl.in_range = {24'd0, i_in.hidden_index} < 32'(HIDDEN);
        n_s1_ctrl.quad     = QUAD_I;
        n_s1_ctrl.embed    = i_in.embed_value;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_ctrl <= '0;
        end else begin
            r_s1_ctrl <= n_s1_ctrl;
        end
        r_s1_freq <= w_freq_rom[i_in.hidden_index[7:1]];
        r_s1_pos  <= i_in.position;
    end

    // Stage 2: phase in turns; the modulo one turn is the dropped high bits.
    logic [PHASE_W+8:0] w_phase;
    t_spe_ctrl          r_s2_ctrl, n_s2_ctrl;
    logic [29:0]        r_s2_rem;

    assign w_phase = (PHASE_W + 9)'(r_s1_freq) * (PHASE_W + 9)'(r_s1_pos);

    always_comb begin
        n_s2_ctrl      = r_s1_ctrl;
        n_s2_ctrl.quad = t_quad'(w_phase[47:46]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_ctrl <= '0;
        end else begin
            r_s2_ctrl <= n_s2_ctrl;
        end
        r_s2_rem  <= w_phase[45:16];
    end

    // Stage 3: angle within the quadrant, turns to nanoradians with rounding.
    logic [63:0] w_nrad;
    t_spe_ctrl   r_s3_ctrl;
    t_cz         r_s3_z;

    assign w_nrad = 64'({r_s2_rem, 32'd0}) + 64'(r_s2_rem) * TWO_PI_LO + ROUND_Q32;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_ctrl <= '0;
        end else begin
            r_s3_ctrl <= r_s2_ctrl;
        end
        r_s3_z    <= t_cz'({2'b00, w_nrad[62:32]});
    end

    // CORDIC chain, three micro-rotations per stage.
    t_spe_ctrl w_c_ctrl [CORDIC_STAGES+1];
    t_cxy      w_c_x    [CORDIC_STAGES+1];
    t_cxy      w_c_y    [CORDIC_STAGES+1];
    t_cz       w_c_z    [CORDIC_STAGES+1];

    assign w_c_ctrl[0] = r_s3_ctrl;
    assign w_c_x[0]    = CORDIC_GAIN_Q30;
    assign w_c_y[0]    = '0;
    assign w_c_z[0]    = r_s3_z;

    for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_cordic
        spe_cordic_stage #(
            .FIRST(s * STAGE_STEPS)
        ) u_stage (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_ctrl (w_c_ctrl[s]),
            .i_x    (w_c_x[s]),
            .i_y    (w_c_y[s]),
            .i_z    (w_c_z[s]),
            .o_ctrl (w_c_ctrl[s+1]),
            .o_x    (w_c_x[s+1]),
            .o_y    (w_c_y[s+1]),
            .o_z    (w_c_z[s+1])
        );
    end

    // Stage 10: quadrant mapping, rounding to Q12 and clamping.
    t_spe_ctrl                r_s10_ctrl;
    logic signed [TERM_W-1:0] r_term, n_term;
    t_spe_ctrl                w_cc;
    t_cxy                     w_cx, w_cy;

    assign w_cc = w_c_ctrl[CORDIC_STAGES];
    assign w_cx = w_c_x[CORDIC_STAGES];
    assign w_cy = w_c_y[CORDIC_STAGES];

    always_comb begin : pick
        t_cxy s;
        t_cxy c;
        t_cxy v;
        t_cxy rnd;
        case (w_cc.quad)
            QUAD_I: begin
                s = w_cy;
                c = w_cx;
            end
            QUAD_II: begin
                s = w_cx;
                c = -w_cy;
            end
            QUAD_III: begin
                s = -w_cy;
                c = -w_cx;
            end
            QUAD_IV: begin
                s = -w_cx;
                c = w_cy;
            end
            default: begin
                s = '0;
                c = '0;
            end
        endcase
        v   = w_cc.use_cos ? c : s;
        rnd = (v + Q12_ROUND) >>> 18;
        if (rnd > TERM_HI) begin
            rnd = TERM_HI;
        end else if (rnd < TERM_LO) begin
            rnd = TERM_LO;
        end
        n_term = w_cc.in_range ? rnd[TERM_W-1:0] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s10_ctrl <= '0;
        end else begin
            r_s10_ctrl <= w_cc;
        end
        r_term     <= n_term;
    end

    // Stage 11: saturating add and result register.
    logic signed [16:0] w_sum;
    logic               r_done;
    t_spe_out           r_result, n_result;

    assign w_sum = $signed({r_s10_ctrl.embed[15], r_s10_ctrl.embed})
                 + $signed({{3{r_term[TERM_W-1]}}, r_term});

    always_comb begin
        n_result.sum_value = w_sum[15:0];
        n_result.saturated = 1'b0;
        if (w_sum[16] != w_sum[15]) begin
            n_result.saturated = 1'b1;
            n_result.sum_value = w_sum[16] ? 16'sh8000 : 16'sh7fff;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_s10_ctrl.valid;
        end
    end

    assign busy     = 1'b0;
    assign o_done   = r_done;
    assign o_result = r_result;

    // Every accepted item strobes a result once it has passed through every pipeline stage.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##11 o_done)
        else $error("result strobe missing after a start transfer");

    // No result appears without a matching start transfer earlier in the pipeline.
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start, 11))
        else $error("result strobe without a matching start transfer");

    // The positional term stays within plus or minus one.
    a_term_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s10_ctrl.valid |-> (r_term <= 14'sd4096 && r_term >= -14'sd4096))
        else $error("positional term out of range");

    // A clipped sum sits on one of the rails.
    a_sat_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.saturated) |->
        (o_result.sum_value == 16'sh7fff || o_result.sum_value == 16'sh8000))
        else $error("saturation flag set with sum off the rails");

endmodule

`default_nettype wire

// ===== hdl/spe_cordic_stage.sv =====
`default_nettype none

module spe_cordic_stage
    import spe_pkg::*;
#(
    parameter int FIRST = 0
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_spe_ctrl i_ctrl,
    input  wire t_cxy      i_x,
    input  wire t_cxy      i_y,
    input  wire t_cz       i_z,
    output t_spe_ctrl      o_ctrl,
    output t_cxy           o_x,
    output t_cxy           o_y,
    output t_cz            o_z
);

    t_spe_ctrl r_ctrl;
    t_cxy      r_x, r_y, n_x, n_y;
    t_cz       r_z, n_z;

    // Rotation-mode micro-rotations, driving the residual angle toward zero.
    always_comb begin : iter
        t_cxy x;
        t_cxy y;
        t_cxy nx;
        t_cz  z;
        x  = i_x;
        y  = i_y;
        z  = i_z;
        nx = i_x;
        for (int k = 0; k < STAGE_STEPS; k++) begin
            if (z >= 0) begin
                nx = x - (y >>> (FIRST + k));
                y  = y + (x >>> (FIRST + k));
                z  = z - ATAN_NRAD[FIRST + k];
            end else begin
                nx = x + (y >>> (FIRST + k));
                y  = y - (x >>> (FIRST + k));
                z  = z + ATAN_NRAD[FIRST + k];
            end
            x = nx;
        end
        n_x = x;
        n_y = y;
        n_z = z;
    end

    // Stage register; the control word is reset, the datapath is not.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl <= '0;
        end else begin
            r_ctrl <= i_ctrl;
        end
        r_x    <= n_x;
        r_y    <= n_y;
        r_z    <= n_z;
    end

    assign o_ctrl = r_ctrl;
    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_z    = r_z;

endmodule

`default_nettype wire
